[sv/psn_pkg.sv]
// Package: widths, types and the sigmoid table for the single-neuron datapath.
package psn_pkg;

   localparam int X_WIDTH        = 16;                      // Q1.15 input and weight
   localparam int PROD_WIDTH     = 2 * X_WIDTH;             // Q2.30 product
   localparam int ACC_WIDTH      = 40;                      // Q10.30 accumulator
   localparam int OUT_WIDTH      = 16;                      // Q0.16 result
   localparam int FRAC_BITS      = 30;
   localparam int SUM_INT_BITS   = 3;                       // lookup range is [-8,8)
   localparam int SUM_WIDTH      = FRAC_BITS + SUM_INT_BITS + 1;
   localparam int SIG_DEPTH_LOG2 = 10;
   localparam int SIG_DEPTH      = 1 << SIG_DEPTH_LOG2;
   localparam int IDX_SHIFT      = SUM_WIDTH - SIG_DEPTH_LOG2;

   typedef logic signed [X_WIDTH-1:0]    x_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [ACC_WIDTH-1:0]  acc_type;
   typedef logic signed [ACC_WIDTH:0]    acc_wide_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;
   typedef logic [SUM_WIDTH:0]           sum_round_type;
   typedef logic [OUT_WIDTH-1:0]         out_type;
   typedef logic [SIG_DEPTH_LOG2-1:0]    idx_type;
   typedef logic [63:0]                  u64_type;
   typedef out_type                      sig_table_type [SIG_DEPTH];

   localparam u64_type Q30_ONE       = 64'd1 << FRAC_BITS;
   localparam u64_type EXP_M1_Q30    = 64'd395007542;     // exp(-1) in Q30
   localparam u64_type OUT_MAX       = (64'd1 << OUT_WIDTH) - 64'd1;
   localparam sum_type SUM_HI        = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam sum_type SUM_LO        = {1'b1, {(SUM_WIDTH-1){1'b0}}};
   localparam sum_round_type IDX_HALF = sum_round_type'(1) << (IDX_SHIFT - 1);

   // Shift-subtract divide, elaboration only (table build).
   function automatic u64_type udiv64(input u64_type num, input u64_type den);
      logic [64:0] rem;
      u64_type     quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-t), t and result in Q30.
   function automatic u64_type exp_neg_q30(input u64_type t);
      u64_type k;
      u64_type f;
      u64_type term;
      u64_type ef;
      u64_type g;
      k    = t >> FRAC_BITS;
      f    = t & (Q30_ONE - 64'd1);
      term = Q30_ONE;
      ef   = Q30_ONE;
      for (int n = 1; n <= 16; n++) begin
         term = udiv64((term * f) >> FRAC_BITS, u64_type'(n));
         ef   = ef + term;
      end
      g = udiv64((64'd1 << 60) + (ef >> 1), ef);
      for (int j = 0; j < 16; j++) begin
         if (u64_type'(j) < k) begin
            g = (g * EXP_M1_Q30 + (Q30_ONE >> 1)) >> FRAC_BITS;
         end
      end
      return g;
   endfunction

   // Entry i stands for -8 + 16*i/DEPTH; nearest rounding, capped at full scale.
   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      u64_type d;
      u64_type a16;
      u64_type a8;
      u64_type mag;
      u64_type t;
      u64_type g;
      u64_type den;
      u64_type num;
      u64_type y;
      logic    neg;
      d = u64_type'(SIG_DEPTH);
      for (int i = 0; i < SIG_DEPTH; i++) begin
         a16 = 64'd16 * u64_type'(i);
         a8  = 64'd8 * d;
         neg = (a16 < a8);
         mag = neg ? (a8 - a16) : (a16 - a8);
         t   = udiv64((mag << FRAC_BITS) + (d >> 1), d);
         g   = exp_neg_q30(t);
         den = Q30_ONE + g;
         num = neg ? (g << 16) : (64'd1 << 46);
         y   = udiv64(num + (den >> 1), den);
         if (y > OUT_MAX) begin
            y = OUT_MAX;
         end
         tbl[i] = y[OUT_WIDTH-1:0];
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

[sv/psn_ifs.sv]
// Interfaces: request (input pair) and response (neuron output) channels.
interface psn_req_if;
   logic                 valid;
   logic                 ready;
   psn_pkg::x_type       x_value;
   psn_pkg::x_type       weight_value;
   logic                 last_element;

   modport source (output valid, output x_value, output weight_value,
                   output last_element, input ready);
   modport sink   (input valid, input x_value, input weight_value,
                   input last_element, output ready);
endinterface

interface psn_rsp_if;
   logic                 valid;
   logic                 ready;
   psn_pkg::out_type     neuron_output;

   modport source (output valid, output neuron_output, input ready);
   modport sink   (input valid, input neuron_output, output ready);
endinterface

[sv/perceptron_sigmoid_neuron.sv]
// Top level: one neuron, multiply-accumulate of Q1.15 pairs, sigmoid lookup on the last word.
//
//   channel   dir   word                                      when
//   req_if    in    x_value, weight_value, last_element       valid && ready
//   rsp_if    out   neuron_output (Q0.16)                      valid && ready
//
// One word per cycle, sustained while no last word waits on a stalled rsp. Four register stages: input, product,
// accumulate (final sum held on a last word), table lookup into rsp register.
// A last word passes the input, product and sum registers into the rsp register before it shows on rsp_if.
// Reset (synchronous) empties the stages and zeroes the accumulator.
// A stalled rsp only holds a last word in the product stage; other words flow until they queue behind it.
module perceptron_sigmoid_neuron (
   input  logic          clock,
   input  logic          reset,
   psn_req_if.sink       req_if,
   psn_rsp_if.source     rsp_if
);

   // stage 1: input register
   logic                 v1_ff, v1_in;
   psn_pkg::x_type       x1_ff, w1_ff;
   logic                 last1_ff;

   // stage 2: product register
   logic                 v2_ff, v2_in;
   psn_pkg::prod_type    prod_ff, prod_in;
   logic                 last2_ff;

   // stage 3: accumulator and held final sum
   psn_pkg::acc_type     acc_ff, acc_in;
   psn_pkg::acc_type     sum_ff;
   logic                 vs_ff, vs_in;

   // stage 4: response register
   logic                 rsp_valid_ff, rsp_valid_in;
   psn_pkg::out_type     rsp_data_ff, rsp_data_in;

   // flow control
   logic                 free_out, adv_s, en3, adv2, adv1;

   // accumulate datapath
   psn_pkg::acc_wide_type acc_sum;
   psn_pkg::acc_type      acc_sat;

   // lookup datapath
   psn_pkg::sum_type       sum_clamped;
   psn_pkg::sum_round_type sum_offset;
   psn_pkg::sum_round_type sum_rounded;
   psn_pkg::idx_type       tbl_idx;

   // --- flow control: a stage moves when the one after it can take its word
   always_comb begin
      free_out = !rsp_valid_ff || rsp_if.ready;
      adv_s    = !vs_ff || free_out;
      en3      = !(v2_ff && last2_ff) || adv_s;   // only a last word needs the sum stage
      adv2     = !v2_ff || en3;
      adv1     = !v1_ff || adv2;
   end

   assign req_if.ready = adv1;

   // --- stage 2 next: signed 16x16 product, exact in 32 bits
   assign prod_in = psn_pkg::prod_type'(psn_pkg::prod_type'(x1_ff) *
                                        psn_pkg::prod_type'(w1_ff));

   // --- stage 3: add and saturate to 40 bits
   always_comb begin
      acc_sum = psn_pkg::acc_wide_type'(acc_ff) + psn_pkg::acc_wide_type'(prod_ff);
      if (acc_sum[psn_pkg::ACC_WIDTH] != acc_sum[psn_pkg::ACC_WIDTH-1]) begin
         acc_sat = acc_sum[psn_pkg::ACC_WIDTH] ?
                   {1'b1, {(psn_pkg::ACC_WIDTH-1){1'b0}}} :
                   {1'b0, {(psn_pkg::ACC_WIDTH-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[psn_pkg::ACC_WIDTH-1:0];
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (v2_ff && en3) begin
         acc_in = last2_ff ? '0 : acc_sat;   // last word clears for the next vector
      end
   end

   // --- stage 4: clamp to [-8,8), offset, round to nearest entry, read table
   always_comb begin
      if (sum_ff[psn_pkg::ACC_WIDTH-1:psn_pkg::SUM_WIDTH-1] ==
          {(psn_pkg::ACC_WIDTH-psn_pkg::SUM_WIDTH+1){sum_ff[psn_pkg::ACC_WIDTH-1]}}) begin
         sum_clamped = sum_ff[psn_pkg::SUM_WIDTH-1:0];
      end else begin
         sum_clamped = sum_ff[psn_pkg::ACC_WIDTH-1] ? psn_pkg::SUM_LO : psn_pkg::SUM_HI;
      end
      // adding 8.0 is a flip of the top bit
      sum_offset  = {1'b0, ~sum_clamped[psn_pkg::SUM_WIDTH-1],
                     sum_clamped[psn_pkg::SUM_WIDTH-2:0]};
      sum_rounded = sum_offset + psn_pkg::IDX_HALF;
      if (sum_rounded[psn_pkg::SUM_WIDTH]) begin
         tbl_idx = '1;   // rounded up past the last entry
      end else begin
         tbl_idx = sum_rounded[psn_pkg::SUM_WIDTH-1:psn_pkg::IDX_SHIFT];
      end
      rsp_data_in = psn_pkg::SIG_TABLE[tbl_idx];
   end

   // --- valid bits
   always_comb begin
      v1_in        = adv1  ? req_if.valid          : v1_ff;
      v2_in        = adv2  ? v1_ff                 : v2_ff;
      vs_in        = adv_s ? (v2_ff && last2_ff)   : vs_ff;
      rsp_valid_in = free_out ? vs_ff              : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         vs_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         vs_ff        <= vs_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (adv1) begin
         x1_ff    <= req_if.x_value;
         w1_ff    <= req_if.weight_value;
         last1_ff <= req_if.last_element;
      end
      if (adv2) begin
         prod_ff  <= prod_in;
         last2_ff <= last1_ff;
      end
      if (adv_s) begin
         sum_ff   <= acc_sat;
      end
      if (free_out && vs_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.neuron_output = rsp_data_ff;

endmodule

[sv/psn_checker.sv]
// Checker: port-level properties of the neuron block, bound to the top level.
module psn_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input psn_pkg::out_type  neuron_output
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(neuron_output))
      else $error("rsp word changed or dropped under stall");

   // no word out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // an empty or draining output never blocks the input
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req blocked while output free");

   // no output after reset until a word could have crossed the input, product and sum registers
   a_rsp_latency: assert property (@(posedge clock)
      $past(reset, 1) || $past(reset, 2) || $past(reset, 3) |-> !rsp_valid)
      else $error("rsp word too soon after reset");

endmodule

bind perceptron_sigmoid_neuron psn_port_checker u_psn_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .neuron_output (rsp_if.neuron_output)
);
